// ===== src/afd_pkg.sv =====
// ----------------------------------------------------------------------------
// afd_pkg
// Shared constants, codes and types for the frame deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package afd_pkg;

  localparam int BUF_BYTES = 64;
  localparam int IDX_W     = $clog2(BUF_BYTES);
  localparam int LEN_W     = 16;

  localparam logic [7:0] DELIM     = 8'h7E;
  localparam logic [7:0] CSUM_BASE = 8'hFF;

  localparam logic [1:0] ST_GOOD    = 2'd0;
  localparam logic [1:0] ST_BADSUM  = 2'd1;
  localparam logic [1:0] ST_TOOLONG = 2'd2;

  typedef enum logic [2:0] {
    S_HUNT,
    S_COLLECT,
    S_ERR,
    S_FETCH,
    S_SEND
  } state_t;

  typedef struct packed {
    logic       start;
    logic       store;
    logic       set_err;
    logic [1:0] err_code;
    logic       emit_init;
    logic       fetch;
    logic       advance;
    logic       show_err;
    logic       show_byte;
  } cmd_t;

  typedef struct packed {
    logic is_delim;
    logic overflow;
    logic len_phase;
    logic too_long;
    logic final_byte;
    logic sum_ok;
    logic rd_last;
  } stat_t;

endpackage

`default_nettype wire

// ===== src/afd_ctrl.sv =====
// ----------------------------------------------------------------------------
// afd_ctrl
// Controller: hunt, collect, error beat and frame replay sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module afd_ctrl
  import afd_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  wire logic  out_stall,
  input  wire stat_t stat,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      S_HUNT: begin
        in_stall = 1'b0;
        if (in_valid && stat.is_delim) begin
          cmd.start  = 1'b1;
          state_next = S_COLLECT;
        end
      end
      S_COLLECT: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (stat.overflow) begin
            cmd.set_err  = 1'b1;
            cmd.err_code = ST_TOOLONG;
            state_next   = S_ERR;
          end else begin
            cmd.store = 1'b1;
            if (stat.len_phase && stat.too_long) begin
              cmd.set_err  = 1'b1;
              cmd.err_code = ST_TOOLONG;
              state_next   = S_ERR;
            end else if (stat.final_byte) begin
              if (stat.sum_ok) begin
                cmd.emit_init = 1'b1;
                state_next    = S_FETCH;
              end else begin
                cmd.set_err  = 1'b1;
                cmd.err_code = ST_BADSUM;
                state_next   = S_ERR;
              end
            end
          end
        end
      end
      S_ERR: begin
        out_valid    = 1'b1;
        cmd.show_err = 1'b1;
        if (!out_stall) begin
          state_next = S_HUNT;
        end
      end
      S_FETCH: begin
        cmd.fetch  = 1'b1;
        state_next = S_SEND;
      end
      S_SEND: begin
        out_valid     = 1'b1;
        cmd.show_byte = 1'b1;
        if (!out_stall) begin
          if (stat.rd_last) begin
            state_next = S_HUNT;
          end else begin
            cmd.advance = 1'b1;
            state_next  = S_FETCH;
          end
        end
      end
      default: begin
        state_next = S_HUNT;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== src/afd_dpath.sv =====
// ----------------------------------------------------------------------------
// afd_dpath
// Datapath: frame buffer, index and length registers, running checksum,
// replay pointer and result fields.
// ----------------------------------------------------------------------------
`default_nettype none

module afd_dpath
  import afd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [7:0]  rx_byte,
  input  wire cmd_t        cmd,
  output stat_t            stat,
  output logic [7:0]       frame_byte,
  output logic [1:0]       status,
  output logic             last
);

  logic [7:0]       frame_store [BUF_BYTES];
  logic [IDX_W-1:0] byte_index;
  logic [LEN_W-1:0] frame_length;
  logic [7:0]       len_hi;
  logic [7:0]       sum;
  logic [1:0]       err_code;
  logic [IDX_W-1:0] rd_ptr;
  logic [7:0]       mem_q;

  logic [IDX_W:0]   idx;
  logic [LEN_W:0]   len_now;
  logic [LEN_W:0]   end_idx;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [7:0]       wr_data;

  assign idx     = {1'b0, byte_index} + (IDX_W+1)'(1);
  assign len_now = {1'b0, len_hi, rx_byte};
  assign end_idx = {1'b0, frame_length} + (LEN_W+1)'(3);

  always_comb begin
    stat.is_delim   = (rx_byte == DELIM);
    stat.overflow   = (idx >= (IDX_W+1)'(BUF_BYTES));
    stat.len_phase  = (idx == (IDX_W+1)'(2));
    stat.too_long   = (len_now + (LEN_W+1)'(4)) > (LEN_W+1)'(BUF_BYTES);
    stat.final_byte = (idx >= (IDX_W+1)'(3)) && ((LEN_W+1)'(idx) == end_idx);
    stat.sum_ok     = (rx_byte == (CSUM_BASE - sum));
    stat.rd_last    = (rd_ptr == byte_index);
  end

  assign wr_en   = cmd.start || cmd.store;
  assign wr_addr = cmd.start ? '0 : idx[IDX_W-1:0];
  assign wr_data = cmd.start ? DELIM : rx_byte;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fetch) begin
      mem_q <= frame_store[rd_ptr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= '0;
      frame_length <= '0;
    end else if (cmd.start) begin
      byte_index <= '0;
    end else if (cmd.store) begin
      byte_index <= idx[IDX_W-1:0];
      if (stat.len_phase) begin
        frame_length <= len_now[LEN_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.store) begin
      if (idx == (IDX_W+1)'(1)) begin
        len_hi <= rx_byte;
      end
      if (stat.len_phase) begin
        sum <= '0;
      end else if (idx >= (IDX_W+1)'(3)) begin
        sum <= sum + rx_byte;
      end
    end
    if (cmd.set_err) begin
      err_code <= cmd.err_code;
    end
    if (cmd.emit_init) begin
      rd_ptr <= '0;
    end else if (cmd.advance) begin
      rd_ptr <= rd_ptr + IDX_W'(1);
    end
  end

  always_comb begin
    frame_byte = 8'd0;
    status     = err_code;
    last       = 1'b1;
    if (cmd.show_byte) begin
      frame_byte = mem_q;
      status     = ST_GOOD;
      last       = stat.rd_last;
    end else if (!cmd.show_err) begin
      status = ST_GOOD;
      last   = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/api_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// api_frame_deframer
// Receive-side parser for 0x7E-delimited, length-prefixed, checksummed frames.
//
// Input channel (in_valid/in_stall, rx_byte): one received byte per beat.
// Bytes are dropped until a 0x7E delimiter; then a big-endian 16-bit length
// L, L data bytes and a checksum byte are buffered (one beat per cycle).
// Output channel (out_valid/out_stall, frame_byte/status/last): a good frame
// is replayed whole, L+4 beats, delimiter through checksum, last on the final
// beat. A bad checksum or a frame with L+4 > BUF_BYTES gives one beat with
// status 1 or 2, frame_byte 0 and last set, then hunting resumes.
// Replay reads each beat from the buffer into a register (fetch state), then
// presents it (send state); the next read starts only once that beat is
// accepted. An error beat shows in the cycle after the byte that raised it.
// in_stall is high for the whole replay or error beat; input is taken only
// while hunting or collecting. A receiver stall holds the beat unchanged.
// Reset returns to hunting; buffer contents are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module api_frame_deframer
  import afd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      frame_byte,
  output logic [1:0]      status,
  output logic            last
);

  cmd_t  cmd;
  stat_t stat;

  afd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  afd_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .rx_byte    (rx_byte),
    .cmd        (cmd),
    .stat       (stat),
    .frame_byte (frame_byte),
    .status     (status),
    .last       (last)
  );

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input taken while a result beat is pending");

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_GOOD) |-> (last && frame_byte == 8'd0))
    else $error("error beat without last or with nonzero byte");

  a_end_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last) |=> (!out_valid && !in_stall))
    else $error("no return to hunting after final beat");

  a_hold_beat: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> (out_valid && $stable(frame_byte) && $stable(last)))
    else $error("stalled beat changed");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for api_frame_deframer. A byte queue feeds the input
// channel with noise, good frames, bad checksums, oversize lengths and cut-off
// frames. A parser model running alongside predicts every output beat, and
// the monitor compares each accepted beat field by field. The run has four
// pacing phases, and the input is drained between phases.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import afd_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    logic [1:0] code;
    logic       fin;
  } beat_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] rx_byte = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] frame_byte;
  logic [1:0] status;
  logic       last;

  logic [7:0] pending_rx[$];
  beat_t      frame_beats_due[$];
  bit         in_fire = 1'b0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  int         errors = 0;

  // parser model state
  bit          rx_collecting = 1'b0;
  int          rx_pos = 0;
  logic [15:0] rx_len = '0;
  logic [7:0]  rx_buf[BUF_BYTES];

  api_frame_deframer dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .rx_byte   (rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .frame_byte(frame_byte),
    .status    (status),
    .last      (last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void parse_byte(input logic [7:0] b);
    logic [7:0] acc;
    int         nxt;
    if (!rx_collecting) begin
      if (b == DELIM) begin
        rx_buf[0]     = DELIM;
        rx_pos        = 0;
        rx_collecting = 1'b1;
      end
      return;
    end
    nxt = rx_pos + 1;
    if (nxt >= BUF_BYTES) begin
      frame_beats_due.push_back('{8'h00, ST_TOOLONG, 1'b1});
      rx_collecting = 1'b0;
      return;
    end
    rx_pos = nxt;
    rx_buf[rx_pos] = b;
    if (rx_pos < 2) return;
    if (rx_pos == 2) begin
      rx_len = {rx_buf[1], rx_buf[2]};
      if (int'(rx_len) + 4 > BUF_BYTES) begin
        frame_beats_due.push_back('{8'h00, ST_TOOLONG, 1'b1});
        rx_collecting = 1'b0;
      end
      return;
    end
    if (rx_pos != int'(rx_len) + 3) return;
    acc = '0;
    for (int i = 3; i < rx_pos; i++) acc = acc + rx_buf[i];
    if (8'(CSUM_BASE - acc) != rx_buf[rx_pos]) begin
      frame_beats_due.push_back('{8'h00, ST_BADSUM, 1'b1});
    end else begin
      for (int i = 0; i <= rx_pos; i++)
        frame_beats_due.push_back('{rx_buf[i], ST_GOOD, i == rx_pos});
    end
    rx_collecting = 1'b0;
  endfunction

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = 8'($urandom); while (b == DELIM);
    return b;
  endfunction

  task automatic add_frame(input int len, input bit corrupt);
    logic [15:0] l;
    logic [7:0]  acc;
    logic [7:0]  b;
    l = 16'(len);
    pending_rx.push_back(DELIM);
    pending_rx.push_back(l[15:8]);
    pending_rx.push_back(l[7:0]);
    if (len + 4 > BUF_BYTES) begin
      repeat ($urandom_range(0, 4)) pending_rx.push_back(noise_byte());
      return;
    end
    acc = '0;
    repeat (len) begin
      b = 8'($urandom);
      acc = acc + b;
      pending_rx.push_back(b);
    end
    b = CSUM_BASE - acc;
    if (corrupt) b = b ^ 8'($urandom_range(1, 255));
    pending_rx.push_back(b);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_rx.size() != 0 || in_valid || frame_beats_due.size() != 0);
  endtask

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_stall <= 1'b0;
    end else begin
      if (!in_valid || in_fire) begin
        if (pending_rx.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          rx_byte  <= pending_rx.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // monitor
  always @(posedge clk) begin
    beat_t due;
    in_fire = in_valid && !in_stall;
    if (!rst) begin
      if (in_fire) parse_byte(rx_byte);
      if (out_valid === 1'b1 && !out_stall) begin
        if (frame_beats_due.size() == 0) begin
          $error("unexpected beat: frame_byte %0h status %0d last %0d",
                 frame_byte, status, last);
          errors++;
        end else begin
          due = frame_beats_due.pop_front();
          if (frame_byte !== due.data) begin
            $error("frame_byte: expected %0h, got %0h", due.data, frame_byte);
            errors++;
          end
          if (status !== due.code) begin
            $error("status: expected %0d, got %0d", due.code, status);
            errors++;
          end
          if (last !== due.fin) begin
            $error("last: expected %0d, got %0d", due.fin, last);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    logic [7:0] directed_bytes[] = '{
      8'h00, 8'hFF,
      DELIM, 8'h00, 8'h00, 8'hFF,
      DELIM, 8'h00, 8'h00, 8'h00,
      DELIM, 8'h00, 8'h3D,
      DELIM, 8'hFF, 8'hFF,
      DELIM, 8'h00, 8'h02, DELIM, 8'h81, 8'h00
    };
    int target;
    int pick;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 59; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 59; end
        default: begin send_idle_pct = 10; recv_stall_pct = 10; end
      endcase
      if (ph == 0) begin
        foreach (directed_bytes[i]) pending_rx.push_back(directed_bytes[i]);
        add_frame(BUF_BYTES - 4, 1'b0);
      end
      target = pending_rx.size() + 85;
      while (pending_rx.size() < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          repeat ($urandom_range(1, 3)) pending_rx.push_back(noise_byte());
        end else if (pick < 12) begin
          // cut-off frame; the next frame's bytes land in its data
          pending_rx.push_back(DELIM);
          repeat ($urandom_range(0, 5)) pending_rx.push_back(8'($urandom));
        end else begin
          pick = $urandom_range(0, 99);
          if (pick < 70)      add_frame($urandom_range(0, 12), $urandom_range(0, 99) < 20);
          else if (pick < 80) add_frame($urandom_range(13, 60), $urandom_range(0, 99) < 20);
          else if (pick < 85) add_frame(BUF_BYTES - 4, $urandom_range(0, 99) < 20);
          else if (pick < 93) add_frame($urandom_range(61, 70), 1'b0);
          else                add_frame($urandom_range(71, 65535), 1'b0);
        end
      end
      drain();
    end
    repeat (200) @(posedge clk);
    if (errors == 0 && frame_beats_due.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sim.f =====
src/afd_pkg.sv
src/afd_ctrl.sv
src/afd_dpath.sv
src/api_frame_deframer.sv
tb/testbench.sv
